// ===== rtl/vlpd_pkg.sv =====
// Package for the varint length-prefixed deframer.
// Holds the parser phases, status codes, register indexes and reset values.
// No dependencies.
package vlpd_pkg;

    localparam int BYTE_BITS          = 8;
    localparam int VARINT_BITS        = 28;
    localparam int VARINT_COUNT_BITS  = 3;
    localparam int SHIFT_BITS         = 5;
    localparam int MAX_PAYLOAD_BITS   = 16;
    localparam int STATUS_BITS        = 3;
    localparam int CFG_ADDR_BITS      = 1;
    localparam int CFG_DATA_BITS      = 28;
    localparam int PAYLOAD_COUNT_BITS = 16;

    localparam logic [VARINT_BITS-1:0]      MAX_PACKET_LEN_RESET  = 28'd33000;
    localparam logic [MAX_PAYLOAD_BITS-1:0] MAX_PAYLOAD_LEN_RESET = 16'd32770;

    localparam logic [CFG_ADDR_BITS-1:0] REG_MAX_PACKET_LEN  = 1'b0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_MAX_PAYLOAD_LEN = 1'b1;

    typedef enum logic [1:0] {
        PH_PKT_LEN,
        PH_PKT_ID,
        PH_PAY_LEN,
        PH_PAYLOAD
    } phase_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_PAYLOAD     = 3'd0,
        ST_EMPTY       = 3'd1,
        ST_VARINT_LONG = 3'd2,
        ST_PKT_LONG    = 3'd3,
        ST_BAD_ID      = 3'd4,
        ST_PAY_LONG    = 3'd5
    } status_t;

    typedef struct packed {
        logic                 valid;
        logic [BYTE_BITS-1:0] payload_byte;
        status_t              status;
        logic                 last;
    } result_t;

endpackage

// ===== rtl/varint_length_prefixed_deframer.sv =====
// Top level of the varint length-prefixed deframer: input register, limit
// registers, output register and the handshakes. Uses vlpd_pkg and vlpd_parser.
//
// Channel   Direction  Transaction contents
// s_axis    in         tdata[7:0] rx_byte
// m_axis    out        tdata[7:0] payload_byte, tuser[2:0] status, tlast last
// cfg       in         cfg_addr 0 max_packet_len, 1 max_payload_len
//
// Each byte passes through the input register, and any result for it through the
// output register, before that result is offered on m_axis.
// One byte is accepted every cycle while m_axis_tready stays high.
// A stall on m_axis holds the output register and then the input register.
// Reset clears the parser to the packet length phase and loads the limits.
module varint_length_prefixed_deframer #(
    parameter int PAYLOAD_COUNT_BITS = vlpd_pkg::PAYLOAD_COUNT_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [7:0]                            s_axis_tdata,   // [7:0] rx_byte
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [7:0]                            m_axis_tdata,   // [7:0] payload_byte
    output logic [vlpd_pkg::STATUS_BITS-1:0]      m_axis_tuser,   // [2:0] status
    output logic                                  m_axis_tlast,
    input  logic                                  cfg_we,
    input  logic [vlpd_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
    input  logic [vlpd_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);

    logic                                         in_valid_reg;
    logic [vlpd_pkg::BYTE_BITS-1:0]               in_byte_reg;
    logic                                         out_valid_reg;
    logic [vlpd_pkg::BYTE_BITS-1:0]               out_byte_reg;
    vlpd_pkg::status_t                            out_status_reg;
    logic                                         out_last_reg;
    logic [vlpd_pkg::VARINT_BITS-1:0]             max_packet_len_reg;
    logic [vlpd_pkg::MAX_PAYLOAD_BITS-1:0]        max_payload_len_reg;

    logic                                         advance;
    logic                                         step;
    vlpd_pkg::result_t                            result;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    vlpd_parser #(
        .PAYLOAD_COUNT_BITS (PAYLOAD_COUNT_BITS)
    ) u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .rx_byte         (in_byte_reg),
        .max_packet_len  (max_packet_len_reg),
        .max_payload_len (max_payload_len_reg),
        .result          (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= result.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
        if (advance && result.valid)
        begin
            out_byte_reg   <= result.payload_byte;
            out_status_reg <= result.status;
            out_last_reg   <= result.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_packet_len_reg  <= vlpd_pkg::MAX_PACKET_LEN_RESET;
            max_payload_len_reg <= vlpd_pkg::MAX_PAYLOAD_LEN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                vlpd_pkg::REG_MAX_PACKET_LEN:
                    max_packet_len_reg  <= cfg_wdata[vlpd_pkg::VARINT_BITS-1:0];
                vlpd_pkg::REG_MAX_PAYLOAD_LEN:
                    max_payload_len_reg <= cfg_wdata[vlpd_pkg::MAX_PAYLOAD_BITS-1:0];
                default:
                    max_packet_len_reg  <= max_packet_len_reg;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

    // Only payload bytes may continue a response.
    a_not_last_is_payload: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == vlpd_pkg::ST_PAYLOAD)
        else $error("non-final result carries a status code");

    // Status results carry a zero data byte.
    a_status_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != vlpd_pkg::ST_PAYLOAD |-> m_axis_tdata == '0)
        else $error("status result with nonzero data byte");

    // Backpressure on the input only when a byte is held.
    a_ready_low_held: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg && out_valid_reg)
        else $error("input stalled with no byte held");

endmodule

// ===== rtl/vlpd_parser.sv =====
// Byte-wise parser state and combinational step logic of the deframer.
// Depends on vlpd_pkg for phases, status codes and the result struct.
module vlpd_parser #(
    parameter int PAYLOAD_COUNT_BITS = vlpd_pkg::PAYLOAD_COUNT_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   step,
    input  logic [vlpd_pkg::BYTE_BITS-1:0]         rx_byte,
    input  logic [vlpd_pkg::VARINT_BITS-1:0]       max_packet_len,
    input  logic [vlpd_pkg::MAX_PAYLOAD_BITS-1:0]  max_payload_len,
    output vlpd_pkg::result_t                      result
);

    vlpd_pkg::phase_t                              phase_reg;
    vlpd_pkg::phase_t                              phase_next;
    logic [vlpd_pkg::VARINT_BITS-1:0]              varint_value_reg;
    logic [vlpd_pkg::VARINT_BITS-1:0]              varint_value_next;
    logic [vlpd_pkg::VARINT_COUNT_BITS-1:0]        varint_bytes_reg;
    logic [vlpd_pkg::VARINT_COUNT_BITS-1:0]        varint_bytes_next;
    logic [PAYLOAD_COUNT_BITS-1:0]                 payload_left_reg;
    logic [PAYLOAD_COUNT_BITS-1:0]                 payload_left_next;

    logic [vlpd_pkg::SHIFT_BITS-1:0]               shift_amt;
    logic [vlpd_pkg::VARINT_BITS-1:0]              merged;
    logic                                          too_many;
    logic                                          more;
    logic                                          pkt_over;
    logic                                          pay_over;
    logic                                          pay_zero;
    logic                                          payload_last;

    always_comb
    begin
        unique case (varint_bytes_reg[1:0])
            2'd0:    shift_amt = 5'd0;
            2'd1:    shift_amt = 5'd7;
            2'd2:    shift_amt = 5'd14;
            2'd3:    shift_amt = 5'd21;
            default: shift_amt = 5'd0;
        endcase
    end

    assign merged       = varint_value_reg
                        | (vlpd_pkg::VARINT_BITS'(rx_byte[6:0]) << shift_amt);
    assign too_many     = varint_bytes_reg[2];
    assign more         = rx_byte[7];
    assign pkt_over     = merged > max_packet_len;
    assign pay_over     = (merged > vlpd_pkg::VARINT_BITS'(max_payload_len))
                        || ((merged >> PAYLOAD_COUNT_BITS) != '0);
    assign pay_zero     = merged == '0;
    assign payload_last = payload_left_reg <= PAYLOAD_COUNT_BITS'(1);

    // Next state.
    always_comb
    begin
        phase_next        = phase_reg;
        varint_value_next = varint_value_reg;
        varint_bytes_next = varint_bytes_reg;
        payload_left_next = payload_left_reg;
        if (step)
        begin
            unique case (phase_reg)
                vlpd_pkg::PH_PKT_LEN:
                begin
                    if (too_many || (!more && pkt_over))
                    begin
                        phase_next        = vlpd_pkg::PH_PKT_LEN;
                        varint_value_next = '0;
                        varint_bytes_next = '0;
                        payload_left_next = '0;
                    end
                    else if (more)
                    begin
                        varint_value_next = merged;
                        varint_bytes_next = varint_bytes_reg + 3'd1;
                    end
                    else
                    begin
                        phase_next        = vlpd_pkg::PH_PKT_ID;
                        varint_value_next = '0;
                        varint_bytes_next = '0;
                    end
                end
                vlpd_pkg::PH_PKT_ID:
                begin
                    if (rx_byte != '0)
                    begin
                        phase_next        = vlpd_pkg::PH_PKT_LEN;
                        payload_left_next = '0;
                    end
                    else
                    begin
                        phase_next        = vlpd_pkg::PH_PAY_LEN;
                    end
                    varint_value_next = '0;
                    varint_bytes_next = '0;
                end
                vlpd_pkg::PH_PAY_LEN:
                begin
                    if (too_many || (!more && (pay_over || pay_zero)))
                    begin
                        phase_next        = vlpd_pkg::PH_PKT_LEN;
                        varint_value_next = '0;
                        varint_bytes_next = '0;
                        payload_left_next = '0;
                    end
                    else if (more)
                    begin
                        varint_value_next = merged;
                        varint_bytes_next = varint_bytes_reg + 3'd1;
                    end
                    else
                    begin
                        phase_next        = vlpd_pkg::PH_PAYLOAD;
                        varint_value_next = '0;
                        varint_bytes_next = '0;
                        payload_left_next = merged[PAYLOAD_COUNT_BITS-1:0];
                    end
                end
                vlpd_pkg::PH_PAYLOAD:
                begin
                    if (payload_last)
                    begin
                        phase_next        = vlpd_pkg::PH_PKT_LEN;
                        varint_value_next = '0;
                        varint_bytes_next = '0;
                        payload_left_next = '0;
                    end
                    else
                    begin
                        payload_left_next = payload_left_reg - PAYLOAD_COUNT_BITS'(1);
                    end
                end
                default:
                begin
                    phase_next = vlpd_pkg::PH_PKT_LEN;
                end
            endcase
        end
    end

    // Result of the current step.
    always_comb
    begin
        result.valid        = 1'b0;
        result.payload_byte = '0;
        result.status       = vlpd_pkg::ST_PAYLOAD;
        result.last         = 1'b1;
        unique case (phase_reg)
            vlpd_pkg::PH_PKT_LEN:
            begin
                if (too_many)
                begin
                    result.valid  = step;
                    result.status = vlpd_pkg::ST_VARINT_LONG;
                end
                else if (!more && pkt_over)
                begin
                    result.valid  = step;
                    result.status = vlpd_pkg::ST_PKT_LONG;
                end
            end
            vlpd_pkg::PH_PKT_ID:
            begin
                if (rx_byte != '0)
                begin
                    result.valid  = step;
                    result.status = vlpd_pkg::ST_BAD_ID;
                end
            end
            vlpd_pkg::PH_PAY_LEN:
            begin
                if (too_many)
                begin
                    result.valid  = step;
                    result.status = vlpd_pkg::ST_VARINT_LONG;
                end
                else if (!more && pay_over)
                begin
                    result.valid  = step;
                    result.status = vlpd_pkg::ST_PAY_LONG;
                end
                else if (!more && pay_zero)
                begin
                    result.valid  = step;
                    result.status = vlpd_pkg::ST_EMPTY;
                end
            end
            vlpd_pkg::PH_PAYLOAD:
            begin
                result.valid        = step;
                result.payload_byte = rx_byte;
                result.last         = payload_last;
            end
            default:
            begin
                result.valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= vlpd_pkg::PH_PKT_LEN;
            varint_value_reg <= '0;
            varint_bytes_reg <= '0;
            payload_left_reg <= '0;
        end
        else
        begin
            phase_reg        <= phase_next;
            varint_value_reg <= varint_value_next;
            varint_bytes_reg <= varint_bytes_next;
            payload_left_reg <= payload_left_next;
        end
    end

endmodule
